[rtl/pm_pkg.sv]
// shared types and constants for the polynomial multiplier
package pm_pkg;

  // widths for the term count; the 5-bit power field limits MAX_TERMS to 16
  localparam int IDX_W_MAX = 5;
  localparam int CNT_W_MAX = 6;
  localparam int COEF_W    = 16;
  localparam int PROD_W    = 32;
  localparam int ACC_W     = 36;
  localparam int POWER_W   = 5;
  localparam int OUT_TDATA_W = 48;

  // one queue entry: an optional store of a coefficient, then an optional product run
  typedef struct packed {
    logic                  do_write;
    logic                  do_run;
    logic                  sel_b;
    logic [IDX_W_MAX-1:0]  idx;
    logic [COEF_W-1:0]     coef;
    logic [CNT_W_MAX-1:0]  cnt_a;
    logic [CNT_W_MAX-1:0]  cnt_b;
    logic                  ovf;
  } cmd_t;

endpackage

[rtl/pm_front.sv]
// load front end: counts coefficients, drops extras and queues stores and runs
module pm_front import pm_pkg::*; #(
  parameter int MAX_TERMS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        s_axis_tlast,
  input  logic        q_full,
  output logic        q_push,
  output cmd_t        q_cmd
);

  localparam int CW = $clog2(MAX_TERMS + 1);

  logic [CW-1:0] count_a, count_b, count_a_next, count_b_next;
  logic          done_a, done_b, done_a_next, done_b_next;
  logic          ovf, ovf_next;
  logic          accept, live, room, wr, run, done_t;
  logic [CW-1:0] cnt_t;

  assign s_axis_tready = !q_full;

  always_comb begin
    accept       = s_axis_tvalid && s_axis_tready;
    done_t       = s_axis_tuser ? done_b : done_a;
    cnt_t        = s_axis_tuser ? count_b : count_a;
    // items for a finished polynomial are ignored while the other is open
    live         = accept && !done_t;
    room         = cnt_t < CW'(MAX_TERMS);
    wr           = live && room;
    count_a_next = count_a + CW'(wr && !s_axis_tuser);
    count_b_next = count_b + CW'(wr && s_axis_tuser);
    done_a_next  = done_a || (live && !s_axis_tuser && s_axis_tlast);
    done_b_next  = done_b || (live && s_axis_tuser && s_axis_tlast);
    ovf_next     = ovf || (live && !room);
    run          = live && done_a_next && done_b_next;
    q_push       = wr || run;
    q_cmd.do_write = wr;
    q_cmd.do_run   = run;
    q_cmd.sel_b    = s_axis_tuser;
    q_cmd.idx      = IDX_W_MAX'(cnt_t);
    q_cmd.coef     = s_axis_tdata;
    q_cmd.cnt_a    = CNT_W_MAX'(count_a_next);
    q_cmd.cnt_b    = CNT_W_MAX'(count_b_next);
    q_cmd.ovf      = ovf_next;
  end

  always_ff @(posedge clk) begin
    if (rst || run) begin
      count_a <= '0;
      count_b <= '0;
      done_a  <= 1'b0;
      done_b  <= 1'b0;
      ovf     <= 1'b0;
    end else begin
      count_a <= count_a_next;
      count_b <= count_b_next;
      done_a  <= done_a_next;
      done_b  <= done_b_next;
      ovf     <= ovf_next;
    end
  end

endmodule

[rtl/pm_cmd_fifo.sv]
// four-entry queue of commands between the front end and the multiply engine
module pm_cmd_fifo import pm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic avail,
  output cmd_t head
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  cmd_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   fill;
  logic             do_push, do_pop;

  assign full    = fill == (PTR_W+1)'(DEPTH);
  assign avail   = fill != '0;
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && avail;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
    end
  end

endmodule

[rtl/pm_back.sv]
// multiply engine: coefficient stores, term sequencer and a shared multiply-accumulate
module pm_back import pm_pkg::*; #(
  parameter int MAX_TERMS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_avail,
  input  cmd_t                   q_head,
  output logic                   q_pop,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tuser,
  output logic                   m_axis_tlast
);

  localparam int IW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CW = $clog2(MAX_TERMS + 1);
  localparam int PW = $clog2(2 * MAX_TERMS);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  typedef struct packed {
    logic               first;
    logic               lastterm;
    logic               final_term;
    logic               ovf;
    logic [POWER_W-1:0] power;
  } tag_t;

  state_t state;

  logic [COEF_W-1:0] mem_a [MAX_TERMS];
  logic [COEF_W-1:0] mem_b [MAX_TERMS];

  logic [CW-1:0] run_ca, run_cb;
  logic          run_ovf;
  logic [PW-1:0] p, j, total_m1, lo_now, lo_nxt, hi_now;
  logic [IW-1:0] i;
  logic          en, issue;
  tag_t          tag0, s1_tag, s2_tag;
  logic          s1_valid, s2_valid;
  logic signed [COEF_W-1:0] a_rd, b_rd;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc, acc_next, out_coef;
  logic [POWER_W-1:0]       out_power;

  // lowest index of a that pairs with a stored b for power q
  function automatic logic [PW-1:0] lo_of(input logic [PW-1:0] q, input logic [CW-1:0] cb);
    if (q >= PW'(cb)) begin
      return q - PW'(cb) + 1'b1;
    end
    return '0;
  endfunction

  // everything downstream of the sequencer stalls while the output waits
  assign en    = !m_axis_tvalid || m_axis_tready;
  assign issue = (state == ST_RUN) && en;
  assign q_pop = (state == ST_IDLE) && q_avail;

  always_comb begin
    total_m1 = PW'(run_ca) + PW'(run_cb) - PW'(2);
    lo_now   = lo_of(p, run_cb);
    lo_nxt   = lo_of(p + 1'b1, run_cb);
    hi_now   = (p < PW'(run_ca)) ? p : PW'(run_ca) - 1'b1;
    j        = p - PW'(i);
    tag0.first      = PW'(i) == lo_now;
    tag0.lastterm   = PW'(i) == hi_now;
    tag0.final_term = tag0.lastterm && (p == total_m1);
    tag0.ovf        = run_ovf;
    tag0.power      = POWER_W'(p);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (q_pop && q_head.do_run) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (issue && tag0.final_term) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_head.do_run) begin
      run_ca  <= CW'(q_head.cnt_a);
      run_cb  <= CW'(q_head.cnt_b);
      run_ovf <= q_head.ovf;
      p       <= '0;
      i       <= '0;
    end else if (issue) begin
      if (tag0.lastterm) begin
        p <= p + 1'b1;
        i <= IW'(lo_nxt);
      end else begin
        i <= i + 1'b1;
      end
    end
  end

  // coefficient stores, read data registered
  always_ff @(posedge clk) begin
    if (q_pop && q_head.do_write && !q_head.sel_b) begin
      mem_a[q_head.idx[IW-1:0]] <= q_head.coef;
    end
    if (q_pop && q_head.do_write && q_head.sel_b) begin
      mem_b[q_head.idx[IW-1:0]] <= q_head.coef;
    end
    if (en) begin
      a_rd <= mem_a[i];
      b_rd <= mem_b[j[IW-1:0]];
    end
  end

  always_comb begin
    acc_next = s2_tag.first ? ACC_W'(prod) : acc + ACC_W'(prod);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_tag <= tag0;
      prod   <= a_rd * b_rd;
      s2_tag <= s1_tag;
      if (s2_valid) begin
        acc <= acc_next;
      end
      if (s2_valid && s2_tag.lastterm) begin
        out_coef     <= acc_next;
        out_power    <= s2_tag.power;
        m_axis_tlast <= s2_tag.final_term;
        m_axis_tuser <= s2_tag.ovf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      s1_valid      <= issue;
      s2_valid      <= s1_valid;
      m_axis_tvalid <= s2_valid && s2_tag.lastterm;
    end
  end

  assign m_axis_tdata = {{(OUT_TDATA_W - ACC_W - POWER_W){1'b0}}, out_power, out_coef};

endmodule

[rtl/polynomial_multiplier_top.sv]
// Polynomial multiplier: load two polynomials of signed Q8.8 coefficients, lowest power
// first, each tagged A or B in tuser and ended by tlast, in any order or interleaved.
// Once both loads are complete, count_a+count_b-1 exact Q20.16 product coefficients
// come out lowest power first, with tlast on the highest; tuser flags a run in which
// coefficients past MAX_TERMS were dropped. Loading takes one item a cycle while the
// four-entry command queue has room. A product run goes through one shared 16x16
// multiply-accumulate, one term a cycle while the output is not stalled, count_a*count_b
// terms in all; during the run the queue takes up to four items of the next pair,
// then loading stalls until the run has issued its last term.
module polynomial_multiplier_top import pm_pkg::*; #(
  parameter int MAX_TERMS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // coef_in
  input  logic        s_axis_tuser,   // which_poly
  input  logic        s_axis_tlast,   // load_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // coef_out [35:0], power [40:36], zero fill
  output logic        m_axis_tuser,   // overflow
  output logic        m_axis_tlast    // out_last
);

  logic q_push, q_full, q_pop, q_avail;
  cmd_t q_cmd, q_head;

  pm_front #(.MAX_TERMS(MAX_TERMS)) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (q_cmd)
  );

  pm_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .avail    (q_avail),
    .head     (q_head)
  );

  pm_back #(.MAX_TERMS(MAX_TERMS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_avail       (q_avail),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

[rtl/pm_checker.sv]
// port-level checks on the polynomial multiplier, bound to the top level
module pm_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  logic [4:0] exp_power;
  logic       mid_run, run_ovf;
  logic       out_acc;

  assign out_acc = m_axis_tvalid && m_axis_tready;

  // expected power and overflow flag of the next result item
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_power <= '0;
      mid_run   <= 1'b0;
      run_ovf   <= 1'b0;
    end else if (out_acc) begin
      exp_power <= m_axis_tlast ? 5'd0 : m_axis_tdata[40:36] + 5'd1;
      mid_run   <= !m_axis_tlast;
      run_ovf   <= m_axis_tuser;
    end
  end

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result item withdrawn while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result item changed");

  a_power_seq: assert property (@(posedge clk) disable iff (rst)
    out_acc |-> m_axis_tdata[40:36] == exp_power)
    else $error("product coefficients out of order");

  a_ovf_steady: assert property (@(posedge clk) disable iff (rst)
    out_acc && mid_run |-> m_axis_tuser == run_ovf)
    else $error("overflow flag changed within a run");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result offered straight after reset");

endmodule

bind polynomial_multiplier_top pm_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
